[hdl/pnr_pkg.sv]
// Package for the palette nearest-neighbor resampler.
// Holds operation codes, register indexes and fixed field widths.
// No dependencies.
`default_nettype none

package pnr_pkg;

	localparam int ADDR_W  = 17;
	localparam int DIM_W   = 10;
	localparam int COLOR_W = 32;
	localparam int PIX_W   = 8;
	localparam int PAL_AW  = 8;
	localparam int PAL_DEPTH = 256;

	// Output image edge; the row and column fields are sized from it
	localparam int OUT_SIZE = 256;
	localparam int OUT_W    = $clog2(OUT_SIZE);

	// Item operation codes (code 3 is unused and yields a zero result)
	localparam logic [1:0] FN_PAL_WR = 2'd0;
	localparam logic [1:0] FN_FRM_WR = 2'd1;
	localparam logic [1:0] FN_PX_RD  = 2'd2;

	// Configuration register indexes
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	localparam logic [DIM_W-1:0] COLS_RESET = 10'd256;
	localparam logic [DIM_W-1:0] ROWS_RESET = 10'd256;

endpackage

`default_nettype wire

[hdl/pnr_req_if.sv]
// Request and response channel interfaces of the resampler.
// Depends on pnr_pkg.
`default_nettype none

interface pnr_req_if;
	import pnr_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [ADDR_W-1:0]  addr;
	logic [COLOR_W-1:0] wdata;
	logic [OUT_W-1:0]   out_row;
	logic [OUT_W-1:0]   out_col;

	modport source (output valid, func, addr, wdata, out_row, out_col, input ready);
	modport sink   (input valid, func, addr, wdata, out_row, out_col, output ready);
endinterface

interface pnr_rsp_if;
	import pnr_pkg::*;

	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] color;
	logic               is_read;

	modport source (output valid, color, is_read, input ready);
	modport sink   (input valid, color, is_read, output ready);
endinterface

`default_nettype wire

[hdl/pnr_fifo.sv]
// Small register FIFO used for the command queue and the result queue.
// No package dependencies.
`default_nettype none

module pnr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           push_data,
	input  wire logic                       pop,
	output logic      [WIDTH-1:0]           head,
	output logic      [$clog2(DEPTH+1)-1:0] count
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign count = count_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNT_W'(DEPTH)) || pop)
		else $error("fifo push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("fifo pop while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q + CNT_W'(push) - CNT_W'(pop)))
		else $error("fifo count mismatch");
`endif

endmodule

`default_nettype wire

[hdl/pnr_regs.sv]
// APB-style configuration registers: source width and height.
// Depends on pnr_pkg.
`default_nettype none

module pnr_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [2:0]                  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output logic      [pnr_pkg::DIM_W-1:0]   cols,
	output logic      [pnr_pkg::DIM_W-1:0]   rows
);
	import pnr_pkg::*;

	logic [DIM_W-1:0] cols_q;
	logic [DIM_W-1:0] rows_q;
	logic             wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_COLS: cols_q <= pwdata[DIM_W-1:0];
				REG_ROWS: rows_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_ROWS) ? {{(32-DIM_W){1'b0}}, rows_q}
	                                       : {{(32-DIM_W){1'b0}}, cols_q};
	assign cols = cols_q;
	assign rows = rows_q;

endmodule

`default_nettype wire

[hdl/pnr_front.sv]
// Front end: accepts items and works out the frame address for each one.
// Two stages: scale products, then row-major address. Depends on pnr_pkg.
`default_nettype none

module pnr_front #(
	parameter int OUT_W    = 8,
	parameter int FRAME_AW = 17,
	parameter int QDEPTH   = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   in_func,
	input  wire logic [pnr_pkg::ADDR_W-1:0]   in_addr,
	input  wire logic [pnr_pkg::COLOR_W-1:0]  in_wdata,
	input  wire logic [OUT_W-1:0]             in_row,
	input  wire logic [OUT_W-1:0]             in_col,
	input  wire logic [pnr_pkg::DIM_W-1:0]    cols,
	input  wire logic [pnr_pkg::DIM_W-1:0]    rows,
	input  wire logic [$clog2(QDEPTH+1)-1:0]  q_count,
	output logic                              cmd_valid,
	output logic      [1:0]                   cmd_func,
	output logic      [FRAME_AW-1:0]          cmd_faddr,
	output logic      [pnr_pkg::COLOR_W-1:0]  cmd_wdata
);
	import pnr_pkg::*;

	localparam int RP_W  = OUT_W + DIM_W;
	localparam int CP_W  = OUT_W + 1 + DIM_W;
	localparam int SUM_W = 2*DIM_W + 1;

	logic                v_s1, v_s2;
	logic [1:0]          func_s1, func_s2;
	logic [ADDR_W-1:0]   addr_s1;
	logic [COLOR_W-1:0]  wdata_s1, wdata_s2;
	logic [RP_W-1:0]     rowp_s1;
	logic [CP_W-1:0]     colp_s1;
	logic [FRAME_AW-1:0] faddr_s2;

	logic                accept;
	logic [DIM_W-1:0]    srow;
	logic [DIM_W-1:0]    scol;
	logic [SUM_W-1:0]    rd_addr;

	// Reserve queue room for everything in flight plus the new item
	assign in_ready = (int'(q_count) + int'(v_s1) + int'(v_s2)) < QDEPTH;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: row and column scale products
	always_ff @(posedge clk) begin
		func_s1  <= in_func;
		addr_s1  <= in_addr;
		wdata_s1 <= in_wdata;
		rowp_s1  <= RP_W'(in_row) * RP_W'(rows);
		colp_s1  <= CP_W'({in_col, 1'b1}) * CP_W'(cols);
	end

	assign srow    = rowp_s1[OUT_W +: DIM_W];
	assign scol    = colp_s1[OUT_W+1 +: DIM_W];
	assign rd_addr = SUM_W'(srow) * SUM_W'(cols) + SUM_W'(scol);

	// Stage 2: frame address, wrapped to the store depth
	always_ff @(posedge clk) begin
		func_s2  <= func_s1;
		wdata_s2 <= wdata_s1;
		case (func_s1)
			FN_PX_RD: faddr_s2 <= FRAME_AW'(rd_addr);
			default:  faddr_s2 <= FRAME_AW'(addr_s1);
		endcase
	end

	assign cmd_valid = v_s2;
	assign cmd_func  = func_s2;
	assign cmd_faddr = faddr_s2;
	assign cmd_wdata = wdata_s2;

endmodule

`default_nettype wire

[hdl/pnr_back.sv]
// Back end: frame store and palette store accesses, one item per cycle
// while the result queue has room. Depends on pnr_pkg.
`default_nettype none

module pnr_back #(
	parameter int FRAME_AW = 17,
	parameter int ODEPTH   = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	input  wire logic [1:0]                   cmd_func,
	input  wire logic [FRAME_AW-1:0]          cmd_faddr,
	input  wire logic [pnr_pkg::COLOR_W-1:0]  cmd_wdata,
	output logic                              cmd_pop,
	input  wire logic [$clog2(ODEPTH+1)-1:0]  o_count,
	output logic                              res_valid,
	output logic      [pnr_pkg::COLOR_W-1:0]  res_color,
	output logic                              res_is_read
);
	import pnr_pkg::*;

	localparam int FRAME_WORDS = 1 << FRAME_AW;

	logic [PIX_W-1:0]   frame_mem [FRAME_WORDS];
	logic [COLOR_W-1:0] pal_mem   [PAL_DEPTH];

	logic               v_s1, v_s2;
	logic [1:0]         func_s1;
	logic [PAL_AW-1:0]  pidx_s1;
	logic [COLOR_W-1:0] wdata_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [COLOR_W-1:0] color_s2;
	logic               is_read_s2;

	// Pop only when the result queue has room for all items in flight
	assign cmd_pop = cmd_valid &&
		((int'(o_count) + int'(v_s1) + int'(v_s2)) < ODEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd_pop;
			v_s2 <= v_s1;
		end
	end

	// Frame store port
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			if (cmd_func == FN_FRM_WR) begin
				frame_mem[cmd_faddr] <= cmd_wdata[PIX_W-1:0];
			end else begin
				pix_s1 <= frame_mem[cmd_faddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		func_s1  <= cmd_func;
		pidx_s1  <= cmd_faddr[PAL_AW-1:0];
		wdata_s1 <= cmd_wdata;
	end

	// Palette store port
	always_ff @(posedge clk) begin
		if (v_s1) begin
			if (func_s1 == FN_PAL_WR) begin
				pal_mem[pidx_s1] <= wdata_s1;
			end else begin
				color_s2 <= pal_mem[pix_s1];
			end
		end
	end

	always_ff @(posedge clk) begin
		is_read_s2 <= (func_s1 == FN_PX_RD);
	end

	assign res_valid   = v_s2;
	assign res_is_read = is_read_s2;
	assign res_color   = is_read_s2 ? color_s2 : '0;

endmodule

`default_nettype wire

[hdl/palette_nearest_resampler_unit.sv]
// Palette nearest-neighbor resampler, top level.
// An accepted item passes through two front stages, the command queue, two store
// stages and the result queue. Throughput: one item per cycle while the sink takes
// results, set by the single port of each store (one access each).
// Reset: control clears at once; cols and rows return to 256; the frame and
// palette stores are undefined until written.
`default_nettype none

module palette_nearest_resampler_unit #(
	parameter int FRAME_WORDS = 131072
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pnr_req_if.sink          req,
	pnr_rsp_if.source        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import pnr_pkg::*;

	// Both sizes are powers of two: divide by shifting, wrap by truncation
	localparam int FRAME_AW = $clog2(FRAME_WORDS);
	localparam int QDEPTH   = 4;
	localparam int ODEPTH   = 4;
	localparam int QCNT_W   = $clog2(QDEPTH+1);
	localparam int OCNT_W   = $clog2(ODEPTH+1);
	localparam int CMD_W    = 2 + FRAME_AW + COLOR_W;
	localparam int RES_W    = COLOR_W + 1;

	logic [DIM_W-1:0]    cols;
	logic [DIM_W-1:0]    rows;

	// front to command queue
	logic                f_valid;
	logic [1:0]          f_func;
	logic [FRAME_AW-1:0] f_faddr;
	logic [COLOR_W-1:0]  f_wdata;

	// command queue to back
	logic [CMD_W-1:0]    q_head;
	logic [QCNT_W-1:0]   q_count;
	logic                q_pop;

	// back to result queue
	logic                b_valid;
	logic [COLOR_W-1:0]  b_color;
	logic                b_is_read;
	logic [RES_W-1:0]    o_head;
	logic [OCNT_W-1:0]   o_count;
	logic                o_pop;

	pnr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cols    (cols),
		.rows    (rows)
	);

	// Accept items and turn reads into frame addresses
	pnr_front #(
		.OUT_W    (OUT_W),
		.FRAME_AW (FRAME_AW),
		.QDEPTH   (QDEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_func   (req.func),
		.in_addr   (req.addr),
		.in_wdata  (req.wdata),
		.in_row    (req.out_row),
		.in_col    (req.out_col),
		.cols      (cols),
		.rows      (rows),
		.q_count   (q_count),
		.cmd_valid (f_valid),
		.cmd_func  (f_func),
		.cmd_faddr (f_faddr),
		.cmd_wdata (f_wdata)
	);

	// Decouple the front from the store pipeline
	pnr_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QDEPTH)
	) u_cmd_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.push_data ({f_func, f_faddr, f_wdata}),
		.pop       (q_pop),
		.head      (q_head),
		.count     (q_count)
	);

	// Carry out store writes and pixel reads in order
	pnr_back #(
		.FRAME_AW (FRAME_AW),
		.ODEPTH   (ODEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_count != '0),
		.cmd_func    (q_head[CMD_W-1 -: 2]),
		.cmd_faddr   (q_head[COLOR_W +: FRAME_AW]),
		.cmd_wdata   (q_head[COLOR_W-1:0]),
		.cmd_pop     (q_pop),
		.o_count     (o_count),
		.res_valid   (b_valid),
		.res_color   (b_color),
		.res_is_read (b_is_read)
	);

	// Hold results until the sink takes them
	pnr_fifo #(
		.WIDTH (RES_W),
		.DEPTH (ODEPTH)
	) u_res_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (b_valid),
		.push_data ({b_is_read, b_color}),
		.pop       (o_pop),
		.head      (o_head),
		.count     (o_count)
	);

	assign rsp.valid   = (o_count != '0);
	assign rsp.color   = o_head[COLOR_W-1:0];
	assign rsp.is_read = o_head[COLOR_W];
	assign o_pop       = rsp.valid && rsp.ready;

endmodule

`default_nettype wire
